// ----- hw/rtl/cprp_pkg.sv -----
// Shared types and constants for the checkpoint record parser.
`default_nettype none
package cprp_pkg;

    localparam int TRAILER_BYTES  = 12;
    localparam int HEADER_BYTES   = 32;
    localparam int MIN_FILE_BYTES = HEADER_BYTES + TRAILER_BYTES;
    localparam int DLY_IDX_W      = $clog2(TRAILER_BYTES);
    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);

    localparam logic [31:0] CRC_POLY      = 32'h82F6_3B78;
    localparam logic [31:0] MAGIC_RESET   = 32'h4B43_4753;
    localparam logic [7:0]  MAXVER_RESET  = 8'd2;
    localparam logic [31:0] FIRED_VERSION = 32'd2;

    localparam logic [7:0] CFG_MAGIC  = 8'd0;
    localparam logic [7:0] CFG_MAXVER = 8'd1;

    typedef enum logic [3:0] {
        PH_MAGIC, PH_VERSION, PH_OFFSET, PH_WMARK, PH_ENTRIES, PH_KEYLEN,
        PH_KEYBYTE, PH_WSTART, PH_WEND, PH_SUM, PH_COUNT, PH_FCOUNT,
        PH_FSTART, PH_FEND, PH_DONE, PH_GARBAGE
    } phase_t;

    localparam logic [3:0] K_VERSION = 4'd0;
    localparam logic [3:0] K_OFFSET  = 4'd1;
    localparam logic [3:0] K_WMARK   = 4'd2;
    localparam logic [3:0] K_ENTRIES = 4'd3;
    localparam logic [3:0] K_KEYLEN  = 4'd4;
    localparam logic [3:0] K_KEYBYTE = 4'd5;
    localparam logic [3:0] K_WSTART  = 4'd6;
    localparam logic [3:0] K_WEND    = 4'd7;
    localparam logic [3:0] K_SUM     = 4'd8;
    localparam logic [3:0] K_COUNT   = 4'd9;
    localparam logic [3:0] K_FCOUNT  = 4'd10;
    localparam logic [3:0] K_FSTART  = 4'd11;
    localparam logic [3:0] K_FEND    = 4'd12;
    localparam logic [3:0] K_STATUS  = 4'd13;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_SHORT    = 3'd1;
    localparam logic [2:0] ST_CRC      = 3'd2;
    localparam logic [2:0] ST_MAGIC    = 3'd3;
    localparam logic [2:0] ST_VERSION  = 3'd4;
    localparam logic [2:0] ST_COUNT    = 3'd5;
    localparam logic [2:0] ST_TRUNC    = 3'd6;
    localparam logic [2:0] ST_GARBAGE  = 3'd7;

    typedef struct packed {
        logic [3:0]  kind;
        logic [63:0] value;
        logic [2:0]  status;
        logic        last;
    } rec_t;

    typedef struct packed {
        logic [1:0] cnt;
        rec_t       rec0;
        rec_t       rec1;
    } push_t;

endpackage
`default_nettype wire

// ----- hw/rtl/cprp_front.sv -----
// Front end: trailer delay line, CRC-32C and field parser; emits records.
`default_nettype none
module cprp_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              accept,
    input  wire logic [7:0]        data_byte,
    input  wire logic              last_byte,
    input  wire logic [31:0]       expected_magic,
    input  wire logic [7:0]        max_version,
    output cprp_pkg::push_t        push
);
    import cprp_pkg::*;

    logic [7:0]  dly_reg  [TRAILER_BYTES];
    logic [7:0]  dly_next [TRAILER_BYTES];
    logic [5:0]  bs_reg, bs_next;
    logic [31:0] crc_reg, crc_next;
    phase_t      ph_reg, ph_next;
    logic [2:0]  idx_reg, idx_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] het_reg, het_next;
    logic [63:0] el_reg, el_next;
    logic [63:0] fl_reg, fl_next;
    logic [31:0] kbl_reg, kbl_next;
    logic [31:0] vs_reg, vs_next;
    logic [2:0]  fe_reg, fe_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TRAILER_BYTES; i++) dly_reg[i] <= 8'd0;
            bs_reg  <= '0;
            crc_reg <= '1;
            ph_reg  <= PH_MAGIC;
            idx_reg <= '0;
            acc_reg <= '0;
            het_reg <= '0;
            el_reg  <= '0;
            fl_reg  <= '0;
            kbl_reg <= '0;
            vs_reg  <= '0;
            fe_reg  <= ST_OK;
        end else if (accept) begin
            for (int i = 0; i < TRAILER_BYTES; i++) dly_reg[i] <= dly_next[i];
            bs_reg  <= bs_next;
            crc_reg <= crc_next;
            ph_reg  <= ph_next;
            idx_reg <= idx_next;
            acc_reg <= acc_next;
            het_reg <= het_next;
            el_reg  <= el_next;
            fl_reg  <= fl_next;
            kbl_reg <= kbl_next;
            vs_reg  <= vs_next;
            fe_reg  <= fe_next;
        end
    end

    logic [7:0]  body;
    logic [31:0] c;
    logic [63:0] acc;
    logic [63:0] tcount;
    logic [31:0] stored;
    logic [2:0]  last_idx;
    logic [2:0]  st;
    rec_t        frec;
    logic        fvalid;

    always_comb begin
        for (int i = 0; i < TRAILER_BYTES; i++) dly_next[i] = dly_reg[i];
        bs_next  = bs_reg;
        crc_next = crc_reg;
        ph_next  = ph_reg;
        idx_next = idx_reg;
        acc_next = acc_reg;
        het_next = het_reg;
        el_next  = el_reg;
        fl_next  = fl_reg;
        kbl_next = kbl_reg;
        vs_next  = vs_reg;
        fe_next  = fe_reg;
        body     = dly_reg[0];
        c        = crc_reg ^ {24'd0, body};
        acc      = acc_reg | ({56'd0, body} << {idx_reg, 3'b000});
        last_idx = (ph_reg == PH_MAGIC || ph_reg == PH_VERSION || ph_reg == PH_KEYLEN)
                   ? 3'd3 : 3'd7;
        fvalid   = 1'b0;
        frec     = '0;

        if (bs_reg >= 6'(TRAILER_BYTES)) begin
            for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            crc_next = c;
            for (int i = 0; i < TRAILER_BYTES - 1; i++) dly_next[i] = dly_reg[i + 1];
            dly_next[TRAILER_BYTES - 1] = data_byte;

            if (ph_reg == PH_KEYBYTE) begin
                kbl_next = kbl_reg - 32'd1;
                if (kbl_next == 32'd0) ph_next = PH_WSTART;
                fvalid = 1'b1;
                frec.kind = K_KEYBYTE;
                frec.value = {56'd0, body};
            end else if (ph_reg == PH_DONE || ph_reg == PH_GARBAGE) begin
                ph_next = PH_GARBAGE;
            end else if (idx_reg != last_idx) begin
                idx_next = idx_reg + 3'd1;
                acc_next = acc;
            end else begin
                idx_next   = '0;
                acc_next   = '0;
                frec.value = acc;
                fvalid     = 1'b1;
                unique case (ph_reg)
                    PH_MAGIC: begin
                        fvalid = 1'b0;
                        if (acc[31:0] != expected_magic && fe_reg == ST_OK) fe_next = ST_MAGIC;
                        ph_next = PH_VERSION;
                    end
                    PH_VERSION: begin
                        vs_next = acc[31:0];
                        if ((vs_next == 32'd0 || vs_next > {24'd0, max_version})
                            && fe_reg == ST_OK) fe_next = ST_VERSION;
                        ph_next = PH_OFFSET;
                        frec.kind = K_VERSION;
                    end
                    PH_OFFSET: begin
                        ph_next = PH_WMARK;
                        frec.kind = K_OFFSET;
                    end
                    PH_WMARK: begin
                        ph_next = PH_ENTRIES;
                        frec.kind = K_WMARK;
                    end
                    PH_ENTRIES: begin
                        het_next = acc;
                        el_next  = acc;
                        if (acc != 64'd0) ph_next = PH_KEYLEN;
                        else ph_next = (vs_reg >= FIRED_VERSION) ? PH_FCOUNT : PH_DONE;
                        frec.kind = K_ENTRIES;
                    end
                    PH_KEYLEN: begin
                        kbl_next = acc[31:0];
                        ph_next  = (acc[31:0] != 32'd0) ? PH_KEYBYTE : PH_WSTART;
                        frec.kind = K_KEYLEN;
                    end
                    PH_WSTART: begin
                        ph_next = PH_WEND;
                        frec.kind = K_WSTART;
                    end
                    PH_WEND: begin
                        ph_next = PH_SUM;
                        frec.kind = K_WEND;
                    end
                    PH_SUM: begin
                        ph_next = PH_COUNT;
                        frec.kind = K_SUM;
                    end
                    PH_COUNT: begin
                        el_next = el_reg - 64'd1;
                        if (el_next != 64'd0) ph_next = PH_KEYLEN;
                        else ph_next = (vs_reg >= FIRED_VERSION) ? PH_FCOUNT : PH_DONE;
                        frec.kind = K_COUNT;
                    end
                    PH_FCOUNT: begin
                        fl_next = acc;
                        ph_next = (acc != 64'd0) ? PH_FSTART : PH_DONE;
                        frec.kind = K_FCOUNT;
                    end
                    PH_FSTART: begin
                        ph_next = PH_FEND;
                        frec.kind = K_FSTART;
                    end
                    PH_FEND: begin
                        fl_next = fl_reg - 64'd1;
                        ph_next = (fl_next != 64'd0) ? PH_FSTART : PH_DONE;
                        frec.kind = K_FEND;
                    end
                    default: begin
                        fvalid = 1'b0;
                    end
                endcase
            end
        end else begin
            dly_next[bs_reg[DLY_IDX_W-1:0]] = data_byte;
        end
        if (bs_reg < 6'(MIN_FILE_BYTES)) bs_next = bs_reg + 6'd1;

        tcount = {dly_next[7], dly_next[6], dly_next[5], dly_next[4],
                  dly_next[3], dly_next[2], dly_next[1], dly_next[0]};
        stored = {dly_next[11], dly_next[10], dly_next[9], dly_next[8]};
        priority if (bs_next < 6'(MIN_FILE_BYTES)) st = ST_SHORT;
        else if (stored != ~crc_next)             st = ST_CRC;
        else if (fe_next != ST_OK)                st = fe_next;
        else if (tcount != het_next)              st = ST_COUNT;
        else if (ph_next == PH_GARBAGE)           st = ST_GARBAGE;
        else if (ph_next != PH_DONE)              st = ST_TRUNC;
        else                                      st = ST_OK;

        push = '0;
        if (accept) begin
            if (fvalid) begin
                push.rec0 = frec;
                push.cnt  = 2'd1;
            end
            if (last_byte) begin
                if (fvalid) begin
                    push.rec1 = '{kind: K_STATUS, value: 64'd0, status: st, last: 1'b1};
                    push.cnt  = 2'd2;
                end else begin
                    push.rec0 = '{kind: K_STATUS, value: 64'd0, status: st, last: 1'b1};
                    push.cnt  = 2'd1;
                end
            end
        end

        // Drop all file state after the final byte.
        if (last_byte) begin
            for (int i = 0; i < TRAILER_BYTES; i++) dly_next[i] = 8'd0;
            bs_next  = '0;
            crc_next = '1;
            ph_next  = PH_MAGIC;
            idx_next = '0;
            acc_next = '0;
            het_next = '0;
            el_next  = '0;
            fl_next  = '0;
            kbl_next = '0;
            vs_next  = '0;
            fe_next  = ST_OK;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/cprp_queue.sv -----
// Back end: short record queue, up to two pushes and one pop per cycle.
`default_nettype none
module cprp_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire cprp_pkg::push_t   push,
    input  wire logic              pop,
    output cprp_pkg::rec_t         head,
    output logic                   not_empty,
    output logic                   room2,
    output logic [2:0]             count
);
    import cprp_pkg::*;

    rec_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_reg, rd_reg;
    logic [2:0]        cnt_reg;
    logic              do_pop;

    assign do_pop    = pop && (cnt_reg != 3'd0);
    assign head      = mem[rd_reg];
    assign not_empty = (cnt_reg != 3'd0);
    assign room2     = (cnt_reg <= 3'(QUEUE_DEPTH - 2));
    assign count     = cnt_reg;

    always_ff @(posedge aclk) begin
        if (push.cnt != 2'd0) mem[wr_reg] <= push.rec0;
        if (push.cnt == 2'd2) mem[wr_reg + QPTR_W'(1)] <= push.rec1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_reg + QPTR_W'(push.cnt);
            rd_reg  <= rd_reg + QPTR_W'(do_pop);
            cnt_reg <= cnt_reg + 3'(push.cnt) - 3'(do_pop);
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/checkpoint_record_parser_core.sv -----
// Records are registered in the record queue and offered on m_* in the order of their requests.
// Throughput: one byte request per cycle; a byte yields at most a field and a status.
// The four-entry record queue sets the rate: s_ready drops while fewer than two slots are free.
// Reset (aresetn low, synchronous): file state, queue and registers return to defaults.
// Bytes leave the twelve-byte trailer delay line into the CRC and parser.
`default_nettype none
module checkpoint_record_parser_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_last_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [3:0]       m_record_kind,
    output logic [63:0]      m_field_value,
    output logic [2:0]       m_status_code,
    output logic             m_last_result,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    import cprp_pkg::*;

    logic [31:0] magic_reg;
    logic [7:0]  maxver_reg;
    logic        s_accept;
    push_t       push;
    rec_t        head;
    logic        q_not_empty, q_room2;
    logic [2:0]  q_count;

    // Configuration writes are always taken; unknown indexes are dropped.
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            magic_reg  <= MAGIC_RESET;
            maxver_reg <= MAXVER_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_MAGIC)  magic_reg  <= cfg_data;
            if (cfg_index == CFG_MAXVER) maxver_reg <= cfg_data[7:0];
        end
    end

    // Hold off requests unless the queue can absorb a field plus a status.
    assign s_ready  = q_room2;
    assign s_accept = s_valid && s_ready;

    cprp_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .accept         (s_accept),
        .data_byte      (s_data_byte),
        .last_byte      (s_last_byte),
        .expected_magic (magic_reg),
        .max_version    (maxver_reg),
        .push           (push)
    );

    cprp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .pop       (m_ready),
        .head      (head),
        .not_empty (q_not_empty),
        .room2     (q_room2),
        .count     (q_count)
    );

    assign m_valid       = q_not_empty;
    assign m_record_kind = head.kind;
    assign m_field_value = head.value;
    assign m_status_code = head.status;
    assign m_last_result = head.last;

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_count <= 3'(QUEUE_DEPTH)) else $error("record queue overflow");
    a_last_gives_status: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_last_byte |=> m_valid) else $error("no record after last byte");
    a_status_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_record_kind == K_STATUS) == m_last_result))
        else $error("status kind and last flag disagree");
    a_push_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_accept |-> push.cnt == 2'd0) else $error("push without request");
`endif

endmodule
`default_nettype wire

// ----- test/checkpoint_record_parser_core_test.sv -----
// Self-checking testbench for the checkpoint record parser core.
`default_nettype none
module checkpoint_record_parser_core_test;
    import cprp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Records that a byte request is predicted to produce.
    typedef struct {
        logic [3:0]  kind;
        logic [63:0] value;
        logic [2:0]  status;
        logic        last;
    } record_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = '0;
    logic        s_last_byte = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [3:0]  m_record_kind;
    logic [63:0] m_field_value;
    logic [2:0]  m_status_code;
    logic        m_last_result;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    checkpoint_record_parser_core u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_data_byte(s_data_byte), .s_last_byte(s_last_byte),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_record_kind(m_record_kind), .m_field_value(m_field_value),
        .m_status_code(m_status_code), .m_last_result(m_last_result),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Predictor copy of the parser state and the registers.
    logic [31:0] magic_reg;
    logic [7:0]  maxver_reg;
    logic [7:0]  pdelay [TRAILER_BYTES];
    int unsigned pseen;
    logic [31:0] pcrc;
    phase_t      pphase;
    int unsigned pidx;
    logic [63:0] pacc, phdr_total, pentries, pfired;
    logic [31:0] pkeys, pver;
    logic [2:0]  perr;

    record_t     pending_records[$];
    int          errors = 0;

    // Control knobs for the receiver and sender.
    bit          no_idle = 1'b0;
    int          rx_hold = 0;

    function automatic void clear_file();
        for (int i = 0; i < TRAILER_BYTES; i++) pdelay[i] = '0;
        pseen = 0; pcrc = '1; pphase = PH_MAGIC; pidx = 0; pacc = '0;
        phdr_total = '0; pentries = '0; pfired = '0; pkeys = '0; pver = '0; perr = ST_OK;
    endfunction

    function automatic void push_record(logic [3:0] k, logic [63:0] v, logic [2:0] s,
                                        logic l);
        record_t r;
        r.kind = k; r.value = v; r.status = s; r.last = l;
        pending_records = {pending_records, r};
    endfunction

    function automatic void leave_entries();
        pphase = (pver >= FIRED_VERSION) ? PH_FCOUNT : PH_DONE;
    endfunction

    // Finish one multi-byte field and advance the phase.
    function automatic void close_field(logic [63:0] v);
        case (pphase)
            PH_MAGIC: begin
                if (v[31:0] != magic_reg && perr == ST_OK) perr = ST_MAGIC;
                pphase = PH_VERSION;
            end
            PH_VERSION: begin
                pver = v[31:0];
                if ((pver == 0 || pver > maxver_reg) && perr == ST_OK) perr = ST_VERSION;
                pphase = PH_OFFSET; push_record(K_VERSION, v, ST_OK, 0);
            end
            PH_OFFSET: begin pphase = PH_WMARK; push_record(K_OFFSET, v, ST_OK, 0); end
            PH_WMARK: begin pphase = PH_ENTRIES; push_record(K_WMARK, v, ST_OK, 0); end
            PH_ENTRIES: begin
                phdr_total = v; pentries = v;
                if (v != 0) pphase = PH_KEYLEN; else leave_entries();
                push_record(K_ENTRIES, v, ST_OK, 0);
            end
            PH_KEYLEN: begin
                pkeys = v[31:0];
                pphase = (pkeys != 0) ? PH_KEYBYTE : PH_WSTART;
                push_record(K_KEYLEN, v, ST_OK, 0);
            end
            PH_WSTART: begin pphase = PH_WEND; push_record(K_WSTART, v, ST_OK, 0); end
            PH_WEND: begin pphase = PH_SUM; push_record(K_WEND, v, ST_OK, 0); end
            PH_SUM: begin pphase = PH_COUNT; push_record(K_SUM, v, ST_OK, 0); end
            PH_COUNT: begin
                pentries = pentries - 1;
                if (pentries != 0) pphase = PH_KEYLEN; else leave_entries();
                push_record(K_COUNT, v, ST_OK, 0);
            end
            PH_FCOUNT: begin
                pfired = v; pphase = (v != 0) ? PH_FSTART : PH_DONE;
                push_record(K_FCOUNT, v, ST_OK, 0);
            end
            PH_FSTART: begin pphase = PH_FEND; push_record(K_FSTART, v, ST_OK, 0); end
            PH_FEND: begin
                pfired = pfired - 1; pphase = (pfired != 0) ? PH_FSTART : PH_DONE;
                push_record(K_FEND, v, ST_OK, 0);
            end
            default: ;
        endcase
    endfunction

    function automatic void parse_body(logic [7:0] b);
        int unsigned flen;
        logic [31:0] c;
        c = pcrc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        pcrc = c;
        if (pphase == PH_KEYBYTE) begin
            pkeys = pkeys - 1;
            if (pkeys == 0) pphase = PH_WSTART;
            push_record(K_KEYBYTE, {56'd0, b}, ST_OK, 0);
        end else if (pphase == PH_DONE || pphase == PH_GARBAGE) begin
            pphase = PH_GARBAGE;
        end else begin
            pacc = pacc | ({56'd0, b} << (pidx * 8));
            flen = (pphase == PH_MAGIC || pphase == PH_VERSION || pphase == PH_KEYLEN) ? 4 : 8;
            if (pidx + 1 < flen) pidx++;
            else begin
                logic [63:0] v;
                v = pacc; pacc = '0; pidx = 0;
                close_field(v);
            end
        end
    endfunction

    function automatic logic [2:0] file_status();
        logic [63:0] tcount;
        logic [31:0] stored;
        if (pseen < MIN_FILE_BYTES) return ST_SHORT;
        tcount = {pdelay[7], pdelay[6], pdelay[5], pdelay[4],
                  pdelay[3], pdelay[2], pdelay[1], pdelay[0]};
        stored = {pdelay[11], pdelay[10], pdelay[9], pdelay[8]};
        if (stored != ~pcrc) return ST_CRC;
        if (perr != ST_OK) return perr;
        if (tcount != phdr_total) return ST_COUNT;
        if (pphase == PH_GARBAGE) return ST_GARBAGE;
        if (pphase != PH_DONE) return ST_TRUNC;
        return ST_OK;
    endfunction

    // Predict the records of one accepted byte request.
    function automatic void predict_byte(logic [7:0] b, logic l);
        if (pseen >= TRAILER_BYTES) begin
            parse_body(pdelay[0]);
            for (int i = 0; i < TRAILER_BYTES - 1; i++) pdelay[i] = pdelay[i + 1];
            pdelay[TRAILER_BYTES - 1] = b;
        end else begin
            pdelay[pseen] = b;
        end
        if (pseen < MIN_FILE_BYTES) pseen++;
        if (l) begin
            push_record(K_STATUS, '0, file_status(), 1);
            clear_file();
        end
    endfunction

    // Receiver: random stalls, optional long hold-off.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= no_idle || ($urandom_range(99) >= 23);
        end
    end

    // Checker: compare each accepted record with the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_records.size() == 0) begin
                $error("unexpected record kind=%0d", m_record_kind);
                errors++;
            end else begin
                record_t e;
                e = pending_records.pop_front();
                if (m_record_kind !== e.kind) begin
                    $error("record_kind exp %0d got %0d", e.kind, m_record_kind); errors++;
                end
                if (m_field_value !== e.value) begin
                    $error("field_value exp %h got %h", e.value, m_field_value); errors++;
                end
                if (m_status_code !== e.status) begin
                    $error("status_code exp %0d got %0d", e.status, m_status_code); errors++;
                end
                if (m_last_result !== e.last) begin
                    $error("last_result exp %0d got %0d", e.last, m_last_result); errors++;
                end
            end
        end
    end

    int n_items = 0;
    int budget;
    int phase_end;

    // Send one byte request; random idle cycles before it unless suppressed.
    // Valid stays up after the accept so the next request can follow at once.
    task automatic send_byte(input logic [7:0] b, input logic l);
        while (!no_idle && $urandom_range(99) < 23) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1; s_data_byte <= b; s_last_byte <= l;
        do @(posedge aclk); while (!s_ready);
        predict_byte(b, l);
        n_items++;
    endtask

    // Valid stays up after the accept; the caller drops it after the last write.
    task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_MAGIC) magic_reg = val;
        else if (idx == CFG_MAXVER) maxver_reg = val[7:0];
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_records.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // File builder: body bytes, then count and CRC trailer.
    logic [7:0] fbody[$];

    function automatic void put_le(logic [63:0] v, int n);
        for (int i = 0; i < n; i++) fbody = {fbody, v[i*8 +: 8]};
    endfunction

    // Build a file; bad_crc, bad_cnt, extra, cut and rnd_magic select optional flaws.
    task automatic send_file(input logic [31:0] ver, input int n_ent, input int n_fired,
                             input bit bad_crc, input bit bad_cnt, input int extra,
                             input int cut, input bit rnd_magic);
        logic [31:0] c;
        logic [7:0]  fl[$];
        fbody.delete();
        put_le(rnd_magic ? {$urandom} : magic_reg, 4);
        put_le(ver, 4);
        put_le({$urandom, $urandom}, 8);
        put_le({$urandom, $urandom}, 8);
        put_le(n_ent, 8);
        for (int e = 0; e < n_ent; e++) begin
            int kl;
            kl = $urandom_range(4);
            put_le(kl, 4);
            repeat (kl) fbody = {fbody, 8'($urandom)};
            repeat (4) put_le({$urandom, $urandom}, 8);
        end
        if (ver >= 2) begin
            put_le(n_fired, 8);
            repeat (2 * n_fired) put_le({$urandom, $urandom}, 8);
        end
        repeat (extra) fbody = {fbody, 8'($urandom)};
        repeat (cut) if (fbody.size() > 0) void'(fbody.pop_back());
        c = '1;
        foreach (fbody[i]) begin
            c = c ^ {24'd0, fbody[i]};
            for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        c = ~c;
        if (bad_crc) c = c ^ 32'h1;
        fl = fbody;
        for (int i = 0; i < 8; i++) fl = {fl, (i == 0) ? 8'(n_ent + int'(bad_cnt)) : 8'd0};
        for (int i = 0; i < 4; i++) fl = {fl, c[i*8 +: 8]};
        foreach (fl[i]) send_byte(fl[i], i == fl.size() - 1);
    endtask

    // Directed table: single-byte and short files with known status.
    typedef struct {
        logic [7:0] data;
        logic       last;
        bit         check;
        logic [2:0] status;
    } row_t;

    row_t dir_rows[] = '{
        '{8'h00, 1'b1, 1'b1, ST_SHORT},
        '{8'hFF, 1'b1, 1'b1, ST_SHORT},
        '{8'hA5, 1'b0, 1'b0, ST_OK},
        '{8'h5A, 1'b0, 1'b0, ST_OK},
        '{8'hFF, 1'b1, 1'b1, ST_SHORT}
    };

    initial begin
        magic_reg = MAGIC_RESET;
        maxver_reg = MAXVER_RESET;
        clear_file();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed byte table.
        foreach (dir_rows[i]) begin
            send_byte(dir_rows[i].data, dir_rows[i].last);
            if (dir_rows[i].check && pending_records[$].status !== dir_rows[i].status) begin
                $error("status_code table exp %0d got %0d",
                       dir_rows[i].status, pending_records[$].status);
                errors++;
            end
        end
        // Directed files: ok v1/v2, zero-entry and zero-fired paths, each error other than a short file.
        send_file(1, 1, 0, 0, 0, 0, 0, 0);
        send_file(2, 0, 0, 0, 0, 0, 0, 0);
        send_file(2, 2, 1, 0, 0, 0, 0, 0);
        send_file(2, 1, 0, 1, 0, 0, 0, 0);
        send_file(2, 1, 1, 0, 0, 0, 0, 1);
        send_file(0, 1, 0, 0, 0, 0, 0, 0);
        send_file(3, 1, 1, 0, 0, 0, 0, 0);
        send_file(1, 1, 0, 0, 1, 0, 0, 0);
        send_file(2, 1, 1, 0, 0, 0, 5, 0);
        send_file(1, 1, 0, 0, 0, 3, 0, 0);
        drain();

        // Pressure: long receiver hold-off while bytes keep coming.
        rx_hold = 60;
        send_file(2, 3, 2, 0, 0, 0, 0, 0);
        drain();

        // Split what is left of the byte budget over the random phases.
        budget = (1350 - n_items) / 5;
        if (budget < 40) budget = 40;

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin write_reg(CFG_MAGIC, 32'h0); write_reg(CFG_MAXVER, 8'd1); end
                1: begin write_reg(CFG_MAGIC, 32'hFFFF_FFFF); write_reg(CFG_MAXVER, 8'd255); end
                2: begin
                    write_reg(CFG_MAGIC, $urandom);
                    write_reg(CFG_MAXVER, $urandom_range(1, 255));
                end
                3: begin write_reg(8'd7, $urandom); write_reg(CFG_MAXVER, 8'd2); end
                default: begin write_reg(CFG_MAGIC, MAGIC_RESET); write_reg(CFG_MAXVER, 8'd3); end
            endcase
            cfg_valid <= 1'b0;
            no_idle = (phase == 1);
            phase_end = n_items + budget;
            while (n_items < phase_end) begin
                int pick;
                pick = $urandom_range(99);
                if (pick < 8) begin
                    int n;
                    n = $urandom_range(1, 50);
                    for (int i = 0; i < n; i++) send_byte(8'($urandom), i == n - 1);
                end else begin
                    send_file($urandom_range(99) < 10 ? $urandom_range(0, 4) : $urandom_range(1, 2),
                              $urandom_range(0, 2), $urandom_range(0, 2),
                              pick < 13, pick >= 13 && pick < 17,
                              (pick >= 17 && pick < 21) ? $urandom_range(1, 3) : 0,
                              (pick >= 21 && pick < 25) ? $urandom_range(1, 6) : 0,
                              pick >= 25 && pick < 29);
                end
            end
            drain();
        end

        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire
